// ===== design/pss_pkg.sv =====
// Package: payload types, command and status codes, controller states.
package pss_pkg;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MERGED_ACTIVE  = 2'd0,
    ST_MERGED_PENDING = 2'd1,
    ST_QUEUED         = 2'd2,
    ST_REJECTED       = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REQ_ACT,
    S_REQ_PEND_RD,
    S_REQ_PEND,
    S_REQ_OUT,
    S_MOVE_RD,
    S_MOVE,
    S_STEP_RD,
    S_STEP_MUL,
    S_STEP_WR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         param_index;
    logic signed [31:0] target_value;
    logic [30:0]        max_step_in;
    logic               log_mode_in;
  } in_req_t;

  typedef struct packed {
    logic               kind;
    logic [1:0]         status;
    logic [7:0]         out_index;
    logic signed [31:0] out_value;
    logic               reached;
    logic               last;
  } out_req_t;

endpackage

// ===== design/parameter_slew_scheduler.sv =====
// Top level: slot table, pending FIFO and active list with a sequencing controller.
//
// Usage: requests come in on in_req_i with in_valid_i / in_stall_o, results go out
// on out_req_o with out_valid_o / out_stall_i. cmd 0 asks a slot for a new target
// and returns one status request; cmd 1 is a tick that returns one value request
// per active update, last set on the final one; cmd 2 writes a slot and returns
// nothing; cmd 3 is dropped.
// Sequencing: a request walks the active list (one entry a cycle) and then the
// pending FIFO (a memory read and a compare per entry) before its status goes out.
// A tick moves pending entries into the active list (a read and a move each), then
// steps each active entry (slot read, multiply, write back, emit).
// A slot write stalls the input while it lands in the slot table.
// The slot memory port and the single shared step datapath set this sequencing.
// One item is in flight at a time; in_stall_o is high while it is at work.
// Reset clears the FIFO pointers, the active count and the controller; slot
// contents are undefined until written. A stalled result holds in the output
// register and the block waits for it.
module parameter_slew_scheduler
  import pss_pkg::*;
#(
  parameter int PARAM_SLOTS   = 256,
  parameter int PENDING_DEPTH = 64,
  parameter int ACTIVE_SLOTS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int SW = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int CW = $clog2(ACTIVE_SLOTS + 1);

  typedef struct packed {
    logic [7:0]         slot;
    logic signed [31:0] target;
  } upd_t;

  // Memories.
  logic signed [31:0] slot_val_mem [PARAM_SLOTS];
  logic [31:0]        slot_cfg_mem [PARAM_SLOTS];
  upd_t               pend_mem     [PENDING_DEPTH];
  upd_t               act_q        [ACTIVE_SLOTS];

  state_e state_q, state_d;
  in_req_t req_q;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, keep_q, keep_d;
  logic [1:0] stat_q, stat_d;
  logic out_valid_q, out_valid_d;
  out_req_t out_q, out_d;
  logic wr_pend_q;

  // Memory access controls.
  logic slot_wr, slot_cfg_wr;
  logic [SW-1:0] slot_addr;
  logic signed [31:0] slot_wdata;
  logic signed [31:0] slot_rd_val;
  logic [31:0] slot_rd_cfg;
  logic pend_wr;
  logic [PW-1:0] pend_raddr, pend_waddr;
  upd_t pend_wdata, pend_rd;
  logic act_wr;
  logic [AW-1:0] act_waddr;
  upd_t act_wdata;
  upd_t cur_q, cur_d;

  // Step datapath registers.
  logic [63:0] lim_q, lim_d;
  logic signed [31:0] val_q, val_d;

  always_ff @(posedge clk_i) begin
    if (slot_wr) slot_val_mem[slot_addr] <= slot_wdata;
    if (slot_cfg_wr) slot_cfg_mem[slot_addr] <= {req_q.max_step_in, req_q.log_mode_in};
    slot_rd_val <= slot_val_mem[slot_addr];
    slot_rd_cfg <= slot_cfg_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pend_wr) pend_mem[pend_waddr] <= pend_wdata;
    pend_rd <= pend_mem[pend_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (act_wr) act_q[act_waddr] <= act_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= (state_q == S_IDLE) ? in_req_i : req_q;
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    keep_q <= keep_d;
    stat_q <= stat_d;
    out_q  <= out_d;
    cur_q  <= cur_d;
    lim_q  <= lim_d;
    val_q  <= val_d;
  end

  logic [PW-1:0] tail_nxt;
  logic [PW-1:0] head_nxt;
  logic out_free;
  logic [31:0] abs_v;
  logic [63:0] lim_c, ms64;
  logic signed [33:0] diff, lims, stp;
  logic done;

  assign tail_nxt = (tail_q == PW'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_nxt = (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  // Logarithmic limit: max_step times |value| in Q16.16, capped at 2^32.
  assign abs_v = slot_rd_val[31] ? 32'(-slot_rd_val) : 32'(slot_rd_val);
  assign ms64  = {33'd0, slot_rd_cfg[31:1]};
  assign lim_c = ms64 * {48'd0, abs_v[31:16]}
               + ((ms64 * {48'd0, abs_v[15:0]}) >> 16);

  // Clamp the step toward the target.
  assign diff = 34'(cur_q.target) - 34'(val_q);
  assign lims = (lim_q > 64'h1_0000_0000) ? 34'sh1_0000_0000 : $signed({1'b0, lim_q[32:0]});
  always_comb begin
    stp = diff;
    if (diff > lims) stp = lims;
    if (diff < -lims) stp = -lims;
  end
  assign done = (32'(34'(val_q) + stp) == cur_q.target);

  always_comb begin
    state_d = state_q;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q;
    ptr_d = ptr_q; idx_d = idx_q; keep_d = keep_q; stat_d = stat_q;
    out_d = out_q; cur_d = cur_q; lim_d = lim_q; val_d = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    slot_wr = 1'b0; slot_cfg_wr = 1'b0;
    slot_addr = SW'(req_q.param_index); slot_wdata = req_q.target_value;
    pend_wr = 1'b0;
    pend_raddr = ptr_q; pend_waddr = tail_q;
    pend_wdata = '{slot: req_q.param_index, target: req_q.target_value};
    act_wr = 1'b0; act_waddr = AW'(idx_q); act_wdata = cur_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        idx_d = '0; keep_d = '0; ptr_d = head_q;
        if (in_valid_i && !wr_pend_q) begin
          case (cmd_e'(in_req_i.cmd))
            CMD_REQUEST: state_d = S_REQ_ACT;
            CMD_TICK:    state_d = S_MOVE_RD;
            CMD_WRITE:   state_d = S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    // Request and tick states. Slot write commands land in the cycle after acceptance, from the captured request.
    case (state_q)
      S_REQ_ACT: begin
        if (32'(req_q.param_index) >= 32'(PARAM_SLOTS)) begin
          stat_d = ST_REJECTED; state_d = S_REQ_OUT;
        end else if (idx_q == cnt_q) begin
          state_d = S_REQ_PEND_RD;
        end else if (act_q[AW'(idx_q)].slot == req_q.param_index) begin
          act_wr = 1'b1;
          act_wdata = '{slot: req_q.param_index, target: req_q.target_value};
          stat_d = ST_MERGED_ACTIVE; state_d = S_REQ_OUT;
        end else idx_d = idx_q + 1'b1;
      end
      S_REQ_PEND_RD: begin
        if (ptr_q == tail_q) begin
          if (tail_nxt == head_q) stat_d = ST_REJECTED;
          else begin
            pend_wr = 1'b1; tail_d = tail_nxt; stat_d = ST_QUEUED;
          end
          state_d = S_REQ_OUT;
        end else state_d = S_REQ_PEND;
      end
      S_REQ_PEND: begin
        if (pend_rd.slot == req_q.param_index) begin
          pend_wr = 1'b1; pend_waddr = ptr_q;
          stat_d = ST_MERGED_PENDING; state_d = S_REQ_OUT;
        end else begin
          ptr_d = (ptr_q == PW'(PENDING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
          pend_raddr = ptr_d;
          state_d = S_REQ_PEND_RD;
        end
      end
      S_REQ_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: 1'b0, status: stat_q, out_index: req_q.param_index,
                    out_value: '0, reached: 1'b0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_MOVE_RD: begin
        pend_raddr = head_q;
        if (head_q != tail_q && cnt_q < CW'(ACTIVE_SLOTS)) state_d = S_MOVE;
        else begin
          idx_d = '0; state_d = (cnt_q == '0) ? S_IDLE : S_STEP_RD;
        end
      end
      S_MOVE: begin
        act_wr = 1'b1; act_waddr = AW'(cnt_q); act_wdata = pend_rd;
        cnt_d = cnt_q + 1'b1; head_d = head_nxt;
        state_d = S_MOVE_RD;
      end
      S_STEP_RD: begin
        cur_d = act_q[AW'(idx_q)];
        slot_addr = SW'(cur_d.slot);
        state_d = S_STEP_MUL;
      end
      S_STEP_MUL: begin
        slot_addr = SW'(cur_q.slot);
        val_d = slot_rd_val;
        lim_d = slot_rd_cfg[0] ? lim_c : {33'd0, slot_rd_cfg[31:1]};
        state_d = S_STEP_WR;
      end
      S_STEP_WR: begin
        slot_addr = SW'(cur_q.slot);
        if (out_free) begin
          slot_wr = 1'b1; slot_wdata = 32'(34'(val_q) + stp);
          out_valid_d = 1'b1;
          out_d = '{kind: 1'b1, status: ST_MERGED_ACTIVE, out_index: cur_q.slot,
                    out_value: slot_wdata, reached: done,
                    last: (idx_q + 1'b1 == cnt_q)};
          if (!done) begin
            act_wr = 1'b1; act_waddr = AW'(keep_q); act_wdata = cur_q;
            keep_d = keep_q + 1'b1;
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (idx_q + 1'b1 == cnt_q) begin
          cnt_d = keep_q; state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_STEP_RD;
        end
      end
      default: ;
    endcase
    // Slot write command: done in the cycle after acceptance.
    if (state_q == S_IDLE && in_valid_i && !wr_pend_q
        && cmd_e'(in_req_i.cmd) == CMD_WRITE) begin
      state_d = S_IDLE;
    end
    if (wr_pend_q && 32'(req_q.param_index) < 32'(PARAM_SLOTS)) begin
      slot_wr = 1'b1; slot_cfg_wr = 1'b1;
      slot_addr = SW'(req_q.param_index); slot_wdata = req_q.target_value;
      in_stall_o = 1'b1;
    end
    if (wr_pend_q) in_stall_o = 1'b1;
  end

  // Flag a captured slot write for the cycle after acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) wr_pend_q <= 1'b0;
    else wr_pend_q <= (state_q == S_IDLE) && !wr_pend_q && in_valid_i
                      && (in_req_i.cmd == CMD_WRITE);
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

// ===== design/pss_checker.sv =====
// Checker: port-level properties of the scheduler, bound to the top level.
module pss_checker
  import pss_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // A status result always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_req_o.kind |-> out_req_o.last && !out_req_o.reached
      && out_req_o.out_value == 0)
    else $error("bad status result");

  // An accepted command blocks the next cycle's acceptance; a dropped one is exempt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.cmd != CMD_NONE |=> in_stall_o)
    else $error("back-to-back accept");

  // Value results carry the merged-active status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.kind |-> out_req_o.status == ST_MERGED_ACTIVE)
    else $error("value result with status");

endmodule

bind parameter_slew_scheduler pss_checker u_pss_checker (.*);
